// File: hw/rtl/ogdm_pkg.sv
// shared types, codes and helpers for the obstacle guarded drive mode controller
package ogdm_pkg;

  // item kinds
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_KEY  = 2'd1;
  localparam logic [1:0] OP_ECHO = 2'd2;

  // drive modes
  localparam logic [2:0] MODE_STOP  = 3'd0;
  localparam logic [2:0] MODE_FWD   = 3'd1;
  localparam logic [2:0] MODE_BACK  = 3'd2;
  localparam logic [2:0] MODE_TRACK = 3'd3;
  localparam logic [2:0] MODE_LEFT  = 3'd4;
  localparam logic [2:0] MODE_RIGHT = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_DRIVE_SPEED    = 3'd0;
  localparam logic [2:0] REG_GUARD_DISTANCE = 3'd1;
  localparam logic [2:0] REG_TURN_TIME_MS   = 3'd2;
  localparam logic [2:0] REG_TURN_RATIO     = 3'd3;
  localparam logic [2:0] REG_TRACK_NEAR     = 3'd4;
  localparam logic [2:0] REG_TRACK_FAR      = 3'd5;
  localparam logic [2:0] REG_TRACK_MAX      = 3'd6;
  localparam logic [2:0] REG_TRACK_SPEED    = 3'd7;

  // command bytes
  localparam logic [7:0] KEY_LF   = 8'h0A;
  localparam logic [7:0] KEY_CR   = 8'h0D;
  localparam logic [7:0] KEY_W_LC = 8'h77;
  localparam logic [7:0] KEY_W_UC = 8'h57;
  localparam logic [7:0] KEY_S_LC = 8'h73;
  localparam logic [7:0] KEY_S_UC = 8'h53;
  localparam logic [7:0] KEY_A_LC = 8'h61;
  localparam logic [7:0] KEY_A_UC = 8'h41;
  localparam logic [7:0] KEY_D_LC = 8'h64;
  localparam logic [7:0] KEY_D_UC = 8'h44;
  localparam logic [7:0] KEY_T_LC = 8'h74;
  localparam logic [7:0] KEY_T_UC = 8'h54;
  localparam logic [7:0] KEY_X_LC = 8'h78;
  localparam logic [7:0] KEY_X_UC = 8'h58;

  // reset values and the elapsed counter limit
  localparam logic [7:0]  RST_DRIVE_SPEED    = 8'd230;
  localparam logic [9:0]  RST_GUARD_DISTANCE = 10'd15;
  localparam logic [15:0] RST_TURN_TIME_MS   = 16'd2800;
  localparam logic [7:0]  RST_TURN_RATIO     = 8'd38;
  localparam logic [9:0]  RST_TRACK_NEAR     = 10'd8;
  localparam logic [9:0]  RST_TRACK_FAR      = 10'd16;
  localparam logic [9:0]  RST_TRACK_MAX      = 10'd50;
  localparam logic [7:0]  RST_TRACK_SPEED    = 8'd200;
  localparam logic [10:0] RST_DISTANCE       = 11'd100;
  localparam logic [15:0] ELAPSED_MAX        = 16'hFFFF;

  // echo_us / 58 as multiply by ceil(2^22 / 58), exact over 16-bit inputs
  localparam int          DIV58_SHIFT = 22;
  localparam logic [32:0] DIV58_RECIP = 33'd72316;

  typedef struct packed {
    logic [7:0]  drive_speed;
    logic [9:0]  guard_distance;
    logic [15:0] turn_time_ms;
    logic [7:0]  turn_ratio;
    logic [9:0]  track_near;
    logic [9:0]  track_far;
    logic [9:0]  track_max;
    logic [7:0]  track_speed;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  right_fwd_duty;
    logic        right_back_on;
    logic [7:0]  left_fwd_duty;
    logic [7:0]  left_back_duty;
    logic [2:0]  drive_mode;
    logic        alarm_led;
    logic [10:0] distance_cm;
  } result_t;

  function automatic logic [10:0] div58(input logic [15:0] x);
    logic [32:0] p;
    p = {17'd0, x} * DIV58_RECIP;
    return p[DIV58_SHIFT +: 11];
  endfunction

endpackage

// File: hw/rtl/ogdm_cfg.sv
// configuration register file
module ogdm_cfg (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [2:0]       wr_index,
  input  logic [15:0]      wr_data,
  output ogdm_pkg::cfg_t   cfg
);

  ogdm_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.drive_speed    <= ogdm_pkg::RST_DRIVE_SPEED;
      regs.guard_distance <= ogdm_pkg::RST_GUARD_DISTANCE;
      regs.turn_time_ms   <= ogdm_pkg::RST_TURN_TIME_MS;
      regs.turn_ratio     <= ogdm_pkg::RST_TURN_RATIO;
      regs.track_near     <= ogdm_pkg::RST_TRACK_NEAR;
      regs.track_far      <= ogdm_pkg::RST_TRACK_FAR;
      regs.track_max      <= ogdm_pkg::RST_TRACK_MAX;
      regs.track_speed    <= ogdm_pkg::RST_TRACK_SPEED;
    end else if (wr_en) begin
      case (wr_index)
        ogdm_pkg::REG_DRIVE_SPEED:    regs.drive_speed    <= wr_data[7:0];
        ogdm_pkg::REG_GUARD_DISTANCE: regs.guard_distance <= wr_data[9:0];
        ogdm_pkg::REG_TURN_TIME_MS:   regs.turn_time_ms   <= wr_data;
        ogdm_pkg::REG_TURN_RATIO:     regs.turn_ratio     <= wr_data[7:0];
        ogdm_pkg::REG_TRACK_NEAR:     regs.track_near     <= wr_data[9:0];
        ogdm_pkg::REG_TRACK_FAR:      regs.track_far      <= wr_data[9:0];
        ogdm_pkg::REG_TRACK_MAX:      regs.track_max      <= wr_data[9:0];
        ogdm_pkg::REG_TRACK_SPEED:    regs.track_speed    <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// File: hw/rtl/ogdm_core.sv
// mode state machine, obstacle latch and wheel drive for one word
module ogdm_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [1:0]          op,
  input  logic [7:0]          key,
  input  logic [15:0]         echo_us,
  input  ogdm_pkg::cfg_t      cfg,
  output ogdm_pkg::result_t   result
);

  logic [2:0]  mode;
  logic        latch;
  logic        led;
  logic [10:0] distance;
  logic [15:0] elapsed;

  logic [2:0]  mode_next;
  logic        latch_next;
  logic        led_next;
  logic [10:0] distance_next;
  logic [15:0] elapsed_next;

  logic [2:0]  mode_upd;
  logic [2:0]  mode_grd;
  logic        led_upd;
  logic [15:0] inner_prod;
  logic [7:0]  inner;
  logic [10:0] near_x, far_x, max_x, guard_x;

  assign inner_prod = {8'd0, cfg.drive_speed} * {8'd0, cfg.turn_ratio};
  assign inner      = inner_prod[15:8];
  assign near_x     = {1'b0, cfg.track_near};
  assign far_x      = {1'b0, cfg.track_far};
  assign max_x      = {1'b0, cfg.track_max};
  assign guard_x    = {1'b0, cfg.guard_distance};

  always_comb begin
    mode_upd      = mode;
    latch_next    = latch;
    led_upd       = led;
    distance_next = distance;
    elapsed_next  = elapsed;

    case (op)
      ogdm_pkg::OP_TICK: begin
        if (elapsed != ogdm_pkg::ELAPSED_MAX) elapsed_next = elapsed + 16'd1;
      end
      ogdm_pkg::OP_KEY: begin
        if (!(key inside {ogdm_pkg::KEY_LF, ogdm_pkg::KEY_CR})) begin
          latch_next = 1'b0;
          led_upd    = 1'b0;
        end
        case (key) inside
          ogdm_pkg::KEY_W_LC, ogdm_pkg::KEY_W_UC: begin
            mode_upd = (distance > guard_x) ? ogdm_pkg::MODE_FWD : ogdm_pkg::MODE_STOP;
          end
          ogdm_pkg::KEY_S_LC, ogdm_pkg::KEY_S_UC: mode_upd = ogdm_pkg::MODE_BACK;
          ogdm_pkg::KEY_A_LC, ogdm_pkg::KEY_A_UC: begin
            mode_upd     = ogdm_pkg::MODE_LEFT;
            elapsed_next = 16'd0;
          end
          ogdm_pkg::KEY_D_LC, ogdm_pkg::KEY_D_UC: begin
            mode_upd     = ogdm_pkg::MODE_RIGHT;
            elapsed_next = 16'd0;
          end
          ogdm_pkg::KEY_T_LC, ogdm_pkg::KEY_T_UC: mode_upd = ogdm_pkg::MODE_TRACK;
          ogdm_pkg::KEY_X_LC, ogdm_pkg::KEY_X_UC: mode_upd = ogdm_pkg::MODE_STOP;
          default: ;
        endcase
      end
      ogdm_pkg::OP_ECHO: begin
        distance_next = ogdm_pkg::div58(echo_us);
        if ((mode inside {ogdm_pkg::MODE_FWD, ogdm_pkg::MODE_LEFT, ogdm_pkg::MODE_RIGHT}) &&
            distance_next != 11'd0 && distance_next < guard_x)
          latch_next = 1'b1;
      end
      default: ;
    endcase

    // latch forces a stop of anything but stop and back
    mode_grd = mode_upd;
    led_next = led_upd;
    if (latch_next && !(mode_upd inside {ogdm_pkg::MODE_STOP, ogdm_pkg::MODE_BACK})) begin
      mode_grd = ogdm_pkg::MODE_STOP;
      led_next = 1'b1;
    end

    // after the guard a set latch leaves only stop or back, so no forward drive to suppress
    mode_next             = mode_grd;
    result                = '0;
    result.alarm_led      = led_next;
    result.distance_cm    = distance_next;
    case (mode_grd)
      ogdm_pkg::MODE_FWD: begin
        result.right_fwd_duty = cfg.drive_speed;
        result.left_fwd_duty  = cfg.drive_speed;
      end
      ogdm_pkg::MODE_BACK: begin
        result.right_back_on  = (cfg.drive_speed != 8'd0);
        result.left_back_duty = cfg.drive_speed;
      end
      ogdm_pkg::MODE_LEFT: begin
        result.right_fwd_duty = cfg.drive_speed;
        result.left_fwd_duty  = inner;
        if (elapsed_next > cfg.turn_time_ms) mode_next = ogdm_pkg::MODE_STOP;
      end
      ogdm_pkg::MODE_RIGHT: begin
        result.right_fwd_duty = inner;
        result.left_fwd_duty  = cfg.drive_speed;
        if (elapsed_next > cfg.turn_time_ms) mode_next = ogdm_pkg::MODE_STOP;
      end
      ogdm_pkg::MODE_TRACK: begin
        if (distance_next != 11'd0 && distance_next < near_x) begin
          result.right_back_on  = (cfg.track_speed != 8'd0);
          result.left_back_duty = cfg.track_speed;
        end else if (distance_next >= near_x && distance_next <= far_x) begin
          result.right_fwd_duty = 8'd0;
        end else if (distance_next > far_x && distance_next <= max_x) begin
          result.right_fwd_duty = cfg.track_speed;
          result.left_fwd_duty  = cfg.track_speed;
        end
      end
      default: ;
    endcase
    result.drive_mode = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= ogdm_pkg::MODE_STOP;
      latch    <= 1'b0;
      led      <= 1'b0;
      distance <= ogdm_pkg::RST_DISTANCE;
      elapsed  <= 16'd0;
    end else if (fire) begin
      mode     <= mode_next;
      latch    <= latch_next;
      led      <= led_next;
      distance <= distance_next;
      elapsed  <= elapsed_next;
    end
  end

endmodule

// File: hw/rtl/obstacle_guarded_drive_mode_fsm_top.sv
// top level: input register, mode core and result register of the drive controller
//
//   port group   dir  handshake                  payload
//   req          in   req_valid / req_stall      op, key, echo_us
//   rsp          out  rsp_valid / rsp_stall      wheel duties, drive_mode, alarm_led, distance_cm
//   cfg          in   cfg_valid / cfg_ready      cfg_index, cfg_data
//
// one word per cycle sustained while rsp_stall is low; a word taken into the input register moves on
// to the result register, with the whole step in the logic between them
// rst is synchronous; state comes back to stop mode, latch clear, distance 100
// a stalled result holds; the input register still takes one more word behind it
// cfg_ready is always high, writes land in the next cycle
module obstacle_guarded_drive_mode_fsm_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  key,
  input  logic [15:0] echo_us,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [7:0]  right_fwd_duty,
  output logic        right_back_on,
  output logic [7:0]  left_fwd_duty,
  output logic [7:0]  left_back_duty,
  output logic [2:0]  drive_mode,
  output logic        alarm_led,
  output logic [10:0] distance_cm,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  ogdm_pkg::cfg_t    cfg;
  ogdm_pkg::result_t result;
  ogdm_pkg::result_t rsp;

  logic        hold_valid;
  logic [1:0]  hold_op;
  logic [7:0]  hold_key;
  logic [15:0] hold_echo;
  logic        accept;
  logic        fire;

  assign cfg_ready = 1'b1;
  assign fire      = hold_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = hold_valid && !fire;
  assign accept    = req_valid && !req_stall;

  ogdm_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ogdm_core u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .op      (hold_op),
    .key     (hold_key),
    .echo_us (hold_echo),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (fire) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_op   <= op;
      hold_key  <= key;
      hold_echo <= echo_us;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= result;
    end
  end

  assign right_fwd_duty = rsp.right_fwd_duty;
  assign right_back_on  = rsp.right_back_on;
  assign left_fwd_duty  = rsp.left_fwd_duty;
  assign left_back_duty = rsp.left_back_duty;
  assign drive_mode     = rsp.drive_mode;
  assign alarm_led      = rsp.alarm_led;
  assign distance_cm    = rsp.distance_cm;

  // a word in the input register is never overwritten before it is processed
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    accept && hold_valid |-> fire)
    else $error("input word overwritten before processing");

  // the alarm only stands while stopped or backing
  a_alarm_mode: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && alarm_led |->
      drive_mode == ogdm_pkg::MODE_STOP || drive_mode == ogdm_pkg::MODE_BACK)
    else $error("alarm lit while driving forward or turning");

  // backing never drives a wheel forward
  a_back_no_fwd: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && drive_mode == ogdm_pkg::MODE_BACK |->
      right_fwd_duty == 8'd0 && left_fwd_duty == 8'd0)
    else $error("forward duty in back mode");

  // a processed word shows up as a result at the next edge
  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp_valid)
    else $error("processed word produced no result");

endmodule
